@@ src/aiger_binary_and_decoder_macros.svh @@
// Assertion macros shared by the AND-section decoder.
`ifndef AIGER_BINARY_AND_DECODER_MACROS_SVH
`define AIGER_BINARY_AND_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABAD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");

// Next-cycle implication, checked outside reset.
`define ABAD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication violated");

`endif

@@ src/abad_pkg.sv @@
package abad_pkg;

   localparam int unsigned OUT_LIT_BITS = 32;
   localparam int unsigned GATE_BITS    = 31;
   localparam logic [2:0]  MAX_COUNT    = 3'd7;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERLONG  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } abad_err_type;

   typedef struct packed {
      logic       section_start;
      logic [7:0] data_byte;
   } abad_item_type;

   typedef struct packed {
      abad_err_type                error_code;
      logic [GATE_BITS-1:0]        gate_number;
      logic [OUT_LIT_BITS-1:0]     second_fanin;
      logic [OUT_LIT_BITS-1:0]     first_fanin;
      logic [OUT_LIT_BITS-1:0]     lhs_literal;
   } abad_result_type;

endpackage

@@ src/abad_in_reg.sv @@
module abad_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   step,
   input  abad_pkg::abad_item_type item_in,
   output abad_pkg::abad_item_type item_out,
   output logic                   valid_out
);
   import abad_pkg::*;

   logic          vld_ff, vld_in;
   abad_item_type item_ff, item_in_nx;

   always_comb begin
      vld_in     = vld_ff;
      item_in_nx = item_ff;
      if (load) begin
         vld_in     = 1'b1;
         item_in_nx = item_in;
      end else if (step) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in_nx;
   end

   assign item_out  = item_ff;
   assign valid_out = vld_ff;

endmodule

@@ src/abad_core.sv @@
`include "aiger_binary_and_decoder_macros.svh"

module abad_core #(
   parameter int unsigned LITERAL_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [30:0]              csr_wdata,
   input  logic                     step,
   input  abad_pkg::abad_item_type  item,
   output logic                     emit,
   output abad_pkg::abad_result_type result
);
   import abad_pkg::*;

   localparam int unsigned EXT_W  = LITERAL_BITS + 49;
   localparam int unsigned WIDE_W = (LITERAL_BITS > 33) ? LITERAL_BITS : 33;
   localparam int unsigned OUT_W  = (LITERAL_BITS > 32) ? LITERAL_BITS : 32;
   localparam logic [LITERAL_BITS-1:0] LHS_STEP  = LITERAL_BITS'(2);
   localparam logic [LITERAL_BITS-1:0] LHS_RESET = LITERAL_BITS'(2);

   logic [30:0]             first_ff, first_in;
   logic [LITERAL_BITS-1:0] acc_ff, acc_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic                    phase_ff, phase_in;
   logic [LITERAL_BITS-1:0] pend_ff, pend_in;
   logic [30:0]             ctr_ff, ctr_in;
   logic                    ovf_ff, ovf_in;
   logic                    unf_ff, unf_in;
   logic [LITERAL_BITS-1:0] lhs_ff, lhs_in;

   logic                    start, more, saturated;
   logic [6:0]              payload;
   logic [LITERAL_BITS-1:0] acc_base, acc_next, lhs_cur, diff0, diff1;
   logic [2:0]              cnt_base, cnt_next;
   logic                    phase_base, ovf_base, unf_base, ovf_next, borrow0, borrow1;
   logic [30:0]             ctr_base;
   logic [5:0]              shift;
   logic [EXT_W-1:0]        shifted;
   logic [31:0]             sum_first, sum_ctr;
   logic [WIDE_W-1:0]       wide_first, wide_ctr;
   logic [OUT_W-1:0]        out_lhs, out_first, out_second;

   always_comb begin
      start      = item.section_start;
      more       = item.data_byte[7];
      payload    = item.data_byte[6:0];
      acc_base   = start ? '0 : acc_ff;
      cnt_base   = start ? 3'd0 : cnt_ff;
      phase_base = start ? 1'b0 : phase_ff;
      ctr_base   = start ? 31'd0 : ctr_ff;
      ovf_base   = start ? 1'b0 : ovf_ff;
      unf_base   = start ? 1'b0 : unf_ff;

      sum_first  = {first_ff, 1'b0};
      wide_first = WIDE_W'(sum_first);
      lhs_cur    = start ? wide_first[LITERAL_BITS-1:0] : lhs_ff;

      shift      = {cnt_base, 3'b000} - {3'b000, cnt_base};
      shifted    = EXT_W'(payload) << shift;
      saturated  = (cnt_base == MAX_COUNT);
      ovf_next   = ovf_base | (saturated ? (|payload) : (|shifted[EXT_W-1:LITERAL_BITS]));
      acc_next   = saturated ? acc_base : (acc_base | shifted[LITERAL_BITS-1:0]);
      cnt_next   = saturated ? cnt_base : cnt_base + 3'd1;

      diff0      = lhs_cur - acc_next;
      borrow0    = acc_next > lhs_cur;
      diff1      = pend_ff - acc_next;
      borrow1    = acc_next > pend_ff;

      first_in = csr_wen ? csr_wdata : first_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      ctr_in   = ctr_ff;
      ovf_in   = ovf_ff;
      unf_in   = unf_ff;
      emit     = 1'b0;

      if (step) begin
         priority if (more) begin
            acc_in   = acc_next;
            cnt_in   = cnt_next;
            phase_in = phase_base;
            ctr_in   = ctr_base;
            ovf_in   = ovf_next;
            unf_in   = unf_base;
         end else if (!phase_base) begin
            acc_in   = '0;
            cnt_in   = 3'd0;
            phase_in = 1'b1;
            pend_in  = diff0;
            ctr_in   = ctr_base;
            ovf_in   = ovf_next;
            unf_in   = unf_base | borrow0;
         end else begin
            emit     = 1'b1;
            acc_in   = '0;
            cnt_in   = 3'd0;
            phase_in = 1'b0;
            ctr_in   = ctr_base + 31'd1;
            ovf_in   = 1'b0;
            unf_in   = 1'b0;
         end
      end

      sum_ctr  = {1'b0, first_ff} + {1'b0, ctr_in};
      wide_ctr = WIDE_W'({sum_ctr, 1'b0});
      lhs_in   = emit ? (lhs_cur + LHS_STEP) : wide_ctr[LITERAL_BITS-1:0];

      out_lhs    = OUT_W'(lhs_cur);
      out_first  = OUT_W'(pend_ff);
      out_second = OUT_W'(diff1);
      result.lhs_literal  = out_lhs[31:0];
      result.first_fanin  = out_first[31:0];
      result.second_fanin = out_second[31:0];
      result.gate_number  = ctr_base;
      priority if (ovf_next) begin
         result.error_code = ERR_OVERLONG;
      end else if (unf_base | borrow1) begin
         result.error_code = ERR_UNDERFLOW;
      end else begin
         result.error_code = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 31'd1;
         acc_ff   <= '0;
         cnt_ff   <= 3'd0;
         phase_ff <= 1'b0;
         ctr_ff   <= 31'd0;
         ovf_ff   <= 1'b0;
         unf_ff   <= 1'b0;
         lhs_ff   <= LHS_RESET;
      end else begin
         first_ff <= first_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         ctr_ff   <= ctr_in;
         ovf_ff   <= ovf_in;
         unf_ff   <= unf_in;
         lhs_ff   <= lhs_in;
      end
      pend_ff <= pend_in;
   end

   `ABAD_ASSERT_IMP(a_emit_in_second_phase, clock, reset, emit, phase_ff && !start)
   `ABAD_ASSERT_IMP(a_more_byte_no_result, clock, reset, step && more, !emit)
   `ABAD_ASSERT_NEXT(a_lhs_advances, clock, reset, emit, lhs_ff == $past(lhs_cur) + LHS_STEP)

endmodule

@@ src/abad_out_reg.sv @@
module abad_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      take,
   input  abad_pkg::abad_result_type result_in,
   output abad_pkg::abad_result_type result_out,
   output logic                      valid_out
);
   import abad_pkg::*;

   logic            vld_ff, vld_in;
   abad_result_type res_ff, res_in;

   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (load) begin
         vld_in = 1'b1;
         res_in = result_in;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

   assign result_out = res_ff;
   assign valid_out  = vld_ff;

endmodule

@@ src/aiger_binary_and_decoder.sv @@
// Decoder for the AND-gate section of a binary AIGER stream.
// The req channel carries one raw byte per transaction in req_tdata; req_tuser is
// high on the first byte of a section and clears the gate counter and varint state.
// Each gate takes two varints; when its second varint ends, one transaction on the
// rsp channel carries the gate literal, both fanin literals, the gate index and an
// error code (overlong varint takes precedence over delta underflow).
// csr_wdata is written into the first AND variable on any cycle with csr_wen high;
// write it only while no transaction is in flight.
// Throughput is one byte per cycle while the receiver does not stall: the byte
// register feeds one decode stage whose accumulator, phase and counter update per
// byte, so state never stalls the stream. A gate's last byte goes through the byte
// register, then the result through the output register, before rsp_tvalid rises.
// When the receiver stalls, the result stays in the output register and the byte
// register still holds one more byte, so req_tready drops only when both are full.
// A synchronous reset empties both registers, sets the first AND variable to one and
// clears the counter, varint and phase state; no initialization pass follows.
module aiger_binary_and_decoder #(
   parameter int unsigned LITERAL_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tuser,   // [0] section_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,   // [31:0] lhs_literal, [63:32] first_fanin,
                                      // [95:64] second_fanin, [126:96] gate_number
   output logic [1:0]    rsp_tuser,   // [1:0] error_code
   input  logic          csr_wen,
   input  logic [30:0]   csr_wdata
);
   import abad_pkg::*;

   abad_item_type   req_item, cur_item;
   abad_result_type core_res, out_res;
   logic            in_vld, step, emit, req_take;

   assign req_item.data_byte     = req_tdata;
   assign req_item.section_start = req_tuser;

   assign step       = in_vld && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_vld || step;
   assign req_take   = req_tvalid && req_tready;

   abad_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_take),
      .step      (step),
      .item_in   (req_item),
      .item_out  (cur_item),
      .valid_out (in_vld)
   );

   abad_core #(
      .LITERAL_BITS (LITERAL_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (cur_item),
      .emit      (emit),
      .result    (core_res)
   );

   abad_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step && emit),
      .take       (rsp_tready),
      .result_in  (core_res),
      .result_out (out_res),
      .valid_out  (rsp_tvalid)
   );

   assign rsp_tdata = {1'b0, out_res.gate_number, out_res.second_fanin,
                       out_res.first_fanin, out_res.lhs_literal};
   assign rsp_tuser = out_res.error_code;

endmodule
